// ===== design/ticket_fifo_with_history_stack_assert.svh =====
// Assertion macros shared by the ticket queue design.
// Each macro is clocked on clock and disabled while reset is high.
`ifndef TICKET_FIFO_WITH_HISTORY_STACK_ASSERT_SVH
`define TICKET_FIFO_WITH_HISTORY_STACK_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define TFH_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tfh assertion failed");

// Consequent holds in the cycle after the antecedent.
`define TFH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tfh assertion failed");

`endif

// ===== design/tfh_pkg.sv =====
package tfh_pkg;

   // store sizes
   localparam int QUEUE_DEPTH   = 64;
   localparam int HISTORY_DEPTH = 64;

   localparam int QA_W  = $clog2(QUEUE_DEPTH);
   localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int HA_W  = $clog2(HISTORY_DEPTH);
   localparam int HC_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int CNT_W = (QC_W > HC_W) ? QC_W : HC_W;

   localparam int ID_W  = 32;

   // request op codes
   localparam logic [2:0] OP_OPEN   = 3'd0;
   localparam logic [2:0] OP_SERVE  = 3'd1;
   localparam logic [2:0] OP_SEARCH = 3'd2;
   localparam logic [2:0] OP_LIST_Q = 3'd3;
   localparam logic [2:0] OP_LIST_H = 3'd4;

   // response status codes
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_FULL      = 3'd1;
   localparam logic [2:0] STS_DUP       = 3'd2;
   localparam logic [2:0] STS_EMPTY     = 3'd3;
   localparam logic [2:0] STS_NOT_FOUND = 3'd4;

   // search location codes
   localparam logic [1:0] LOC_NONE    = 2'd0;
   localparam logic [1:0] LOC_QUEUE   = 2'd1;
   localparam logic [1:0] LOC_HISTORY = 2'd2;

   // circular queue slot: (head + off) wrapped once at the queue depth
   function automatic logic [QA_W-1:0] qslot(input logic [QA_W-1:0] head,
                                             input logic [QC_W-1:0] off);
      logic [QC_W:0] sum;
      sum = (QC_W+1)'(head) + (QC_W+1)'(off);
      if (sum >= (QC_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (QC_W+1)'(QUEUE_DEPTH);
      end
      return sum[QA_W-1:0];
   endfunction

endpackage

// ===== design/tfh_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module tfh_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ticket_fifo_with_history_stack.sv =====
// Ticket queue with a service history. Ticket IDs wait in a circular queue held in one
// RAM; served tickets are pushed onto a last-in-first-out history held in a second RAM.
// One request is processed at a time; a new request is taken as soon as the previous one
// has placed its last response word in the output register, even while that word still
// waits to be taken. Both RAMs have a registered read and one read port each, which
// sets the timing: open and search scan the queue, then the history, one entry per cycle
// with the compare pipelined behind the read, and a match ends the scan early; serve
// reads the head entry and then finishes; list queue and list history read and then emit
// each word in turn, waiting while the output is held; an unused op code gives no response.
// An open is refused at once when the queue is full, without a scan.
// The stores need no clearing after reset: only entries within the current counts are read.
`include "ticket_fifo_with_history_stack_assert.svh"

module ticket_fifo_with_history_stack (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] ticket_id
   input  logic [2:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_id
   output logic [5:0]  rsp_tuser,   // [2:0] status, [4:3] location, [5] history_dropped
   output logic        rsp_tlast
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QSCAN,
      ST_HSCAN,
      ST_SERVE_RD,
      ST_SERVE_DATA,
      ST_FINISH,
      ST_QLIST_RD,
      ST_QLIST_OUT,
      ST_HLIST_RD,
      ST_HLIST_OUT
   } state_type;

   state_type                   state_ff;
   logic [2:0]                  op_ff;
   logic [tfh_pkg::ID_W-1:0]    id_ff;
   logic [tfh_pkg::CNT_W-1:0]   n_ff;
   logic                        pend_ff;

   logic [tfh_pkg::QA_W-1:0]    head_ff;
   logic [tfh_pkg::QC_W-1:0]    qcount_ff;
   logic [tfh_pkg::HC_W-1:0]    hcount_ff;

   logic [2:0]                  res_status_ff;
   logic [tfh_pkg::ID_W-1:0]    res_id_ff;
   logic [1:0]                  res_loc_ff;
   logic                        res_drop_ff;

   logic                        rsp_valid_ff;
   logic [2:0]                  rsp_status_ff;
   logic [tfh_pkg::ID_W-1:0]    rsp_id_ff;
   logic [1:0]                  rsp_loc_ff;
   logic                        rsp_drop_ff;
   logic                        rsp_last_ff;

   logic                        q_rd_en;
   logic [tfh_pkg::QA_W-1:0]    q_rd_addr;
   logic [tfh_pkg::ID_W-1:0]    q_rd_data;
   logic                        q_wr_en;
   logic [tfh_pkg::QA_W-1:0]    q_wr_addr;
   logic                        h_rd_en;
   logic [tfh_pkg::HA_W-1:0]    h_rd_addr;
   logic [tfh_pkg::ID_W-1:0]    h_rd_data;
   logic                        h_wr_en;
   logic [tfh_pkg::HA_W-1:0]    h_wr_addr;

   logic                        out_free;
   logic                        rsp_load;
   logic                        q_issue;
   logic                        h_issue;
   logic                        q_match;
   logic                        h_match;
   logic                        q_full;
   logic                        h_full;
   logic                        q_list_last;
   logic                        h_list_last;

   // status of counters and compares
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_load    = out_free && ((state_ff == ST_FINISH) || (state_ff == ST_QLIST_OUT) ||
                                     (state_ff == ST_HLIST_OUT));
   assign q_full      = (qcount_ff == tfh_pkg::QC_W'(tfh_pkg::QUEUE_DEPTH));
   assign h_full      = (hcount_ff == tfh_pkg::HC_W'(tfh_pkg::HISTORY_DEPTH));
   assign q_issue     = (n_ff < tfh_pkg::CNT_W'(qcount_ff));
   assign h_issue     = (n_ff < tfh_pkg::CNT_W'(hcount_ff));
   assign q_match     = pend_ff && (q_rd_data == id_ff);
   assign h_match     = pend_ff && (h_rd_data == id_ff);
   assign q_list_last = ((n_ff + tfh_pkg::CNT_W'(1)) == tfh_pkg::CNT_W'(qcount_ff));
   assign h_list_last = (n_ff == tfh_pkg::CNT_W'(1));

   // drive RAM ports
   always_comb begin
      q_rd_en   = ((state_ff == ST_QSCAN) && q_issue) || (state_ff == ST_SERVE_RD) ||
                  (state_ff == ST_QLIST_RD);
      q_rd_addr = tfh_pkg::qslot(head_ff, n_ff[tfh_pkg::QC_W-1:0]);
      h_rd_en   = ((state_ff == ST_HSCAN) && h_issue) || (state_ff == ST_HLIST_RD);
      if (state_ff == ST_HLIST_RD) begin
         h_rd_addr = tfh_pkg::HA_W'(n_ff - tfh_pkg::CNT_W'(1));
      end else begin
         h_rd_addr = n_ff[tfh_pkg::HA_W-1:0];
      end
      q_wr_en   = (state_ff == ST_FINISH) && out_free && (op_ff == tfh_pkg::OP_OPEN) &&
                  (res_status_ff == tfh_pkg::STS_OK);
      q_wr_addr = tfh_pkg::qslot(head_ff, qcount_ff);
      h_wr_en   = (state_ff == ST_FINISH) && out_free && (op_ff == tfh_pkg::OP_SERVE) &&
                  (res_status_ff == tfh_pkg::STS_OK) && !res_drop_ff;
      h_wr_addr = hcount_ff[tfh_pkg::HA_W-1:0];
   end

   tfh_ram #(
      .DEPTH (tfh_pkg::QUEUE_DEPTH),
      .WIDTH (tfh_pkg::ID_W)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (id_ff),
      .rd_en   (q_rd_en),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   tfh_ram #(
      .DEPTH (tfh_pkg::HISTORY_DEPTH),
      .WIDTH (tfh_pkg::ID_W)
   ) u_history_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (res_id_ff),
      .rd_en   (h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   // sequencer: state, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         head_ff      <= '0;
         qcount_ff    <= '0;
         hcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the response word once taken, unless a new one loads below
         if (rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff       <= req_tuser;
                  id_ff       <= req_tdata;
                  n_ff        <= (req_tuser == tfh_pkg::OP_LIST_H) ?
                                 tfh_pkg::CNT_W'(hcount_ff) : '0;
                  pend_ff     <= 1'b0;
                  res_id_ff   <= '0;
                  res_loc_ff  <= tfh_pkg::LOC_NONE;
                  res_drop_ff <= 1'b0;
                  case (req_tuser)
                     tfh_pkg::OP_OPEN: begin
                        if (q_full) begin
                           res_status_ff <= tfh_pkg::STS_FULL;
                           state_ff      <= ST_FINISH;
                        end else begin
                           state_ff <= ST_QSCAN;
                        end
                     end
                     tfh_pkg::OP_SERVE: begin
                        if (qcount_ff == '0) begin
                           res_status_ff <= tfh_pkg::STS_EMPTY;
                           state_ff      <= ST_FINISH;
                        end else begin
                           state_ff <= ST_SERVE_RD;
                        end
                     end
                     tfh_pkg::OP_SEARCH: begin
                        state_ff <= ST_QSCAN;
                     end
                     tfh_pkg::OP_LIST_Q: begin
                        if (qcount_ff == '0) begin
                           res_status_ff <= tfh_pkg::STS_EMPTY;
                           state_ff      <= ST_FINISH;
                        end else begin
                           state_ff <= ST_QLIST_RD;
                        end
                     end
                     tfh_pkg::OP_LIST_H: begin
                        if (hcount_ff == '0) begin
                           res_status_ff <= tfh_pkg::STS_EMPTY;
                           state_ff      <= ST_FINISH;
                        end else begin
                           state_ff <= ST_HLIST_RD;
                        end
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            // scan the queue, compare in the cycle after the read
            ST_QSCAN: begin
               if (q_match) begin
                  pend_ff <= 1'b0;
                  if (op_ff == tfh_pkg::OP_OPEN) begin
                     res_status_ff <= tfh_pkg::STS_DUP;
                  end else begin
                     res_status_ff <= tfh_pkg::STS_OK;
                     res_id_ff     <= id_ff;
                     res_loc_ff    <= tfh_pkg::LOC_QUEUE;
                  end
                  state_ff <= ST_FINISH;
               end else if (q_issue) begin
                  n_ff    <= n_ff + tfh_pkg::CNT_W'(1);
                  pend_ff <= 1'b1;
               end else begin
                  n_ff     <= '0;
                  pend_ff  <= 1'b0;
                  state_ff <= ST_HSCAN;
               end
            end
            // scan the history the same way
            ST_HSCAN: begin
               if (h_match) begin
                  pend_ff <= 1'b0;
                  if (op_ff == tfh_pkg::OP_OPEN) begin
                     res_status_ff <= tfh_pkg::STS_DUP;
                  end else begin
                     res_status_ff <= tfh_pkg::STS_OK;
                     res_id_ff     <= id_ff;
                     res_loc_ff    <= tfh_pkg::LOC_HISTORY;
                  end
                  state_ff <= ST_FINISH;
               end else if (h_issue) begin
                  n_ff    <= n_ff + tfh_pkg::CNT_W'(1);
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  if (op_ff == tfh_pkg::OP_OPEN) begin
                     res_status_ff <= tfh_pkg::STS_OK;
                  end else begin
                     res_status_ff <= tfh_pkg::STS_NOT_FOUND;
                  end
                  state_ff <= ST_FINISH;
               end
            end
            ST_SERVE_RD: begin
               state_ff <= ST_SERVE_DATA;
            end
            ST_SERVE_DATA: begin
               res_status_ff <= tfh_pkg::STS_OK;
               res_id_ff     <= q_rd_data;
               res_drop_ff   <= h_full;
               state_ff      <= ST_FINISH;
            end
            // emit the single response and commit the state change
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_id_ff     <= res_id_ff;
                  rsp_loc_ff    <= res_loc_ff;
                  rsp_drop_ff   <= res_drop_ff;
                  rsp_last_ff   <= 1'b1;
                  if (res_status_ff == tfh_pkg::STS_OK) begin
                     if (op_ff == tfh_pkg::OP_OPEN) begin
                        qcount_ff <= qcount_ff + tfh_pkg::QC_W'(1);
                     end
                     if (op_ff == tfh_pkg::OP_SERVE) begin
                        head_ff   <= tfh_pkg::qslot(head_ff, tfh_pkg::QC_W'(1));
                        qcount_ff <= qcount_ff - tfh_pkg::QC_W'(1);
                        if (!res_drop_ff) begin
                           hcount_ff <= hcount_ff + tfh_pkg::HC_W'(1);
                        end
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_QLIST_RD: begin
               state_ff <= ST_QLIST_OUT;
            end
            // emit queue entries oldest first
            ST_QLIST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= tfh_pkg::STS_OK;
                  rsp_id_ff     <= q_rd_data;
                  rsp_loc_ff    <= tfh_pkg::LOC_NONE;
                  rsp_drop_ff   <= 1'b0;
                  rsp_last_ff   <= q_list_last;
                  n_ff          <= n_ff + tfh_pkg::CNT_W'(1);
                  state_ff      <= q_list_last ? ST_IDLE : ST_QLIST_RD;
               end
            end
            ST_HLIST_RD: begin
               state_ff <= ST_HLIST_OUT;
            end
            // emit history entries newest first
            ST_HLIST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= tfh_pkg::STS_OK;
                  rsp_id_ff     <= h_rd_data;
                  rsp_loc_ff    <= tfh_pkg::LOC_NONE;
                  rsp_drop_ff   <= 1'b0;
                  rsp_last_ff   <= h_list_last;
                  n_ff          <= n_ff - tfh_pkg::CNT_W'(1);
                  state_ff      <= h_list_last ? ST_IDLE : ST_HLIST_RD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = {rsp_drop_ff, rsp_loc_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks on counters, writes and sequencing
   `TFH_ASSERT_IMP(a_qcount_range, 1'b1, qcount_ff <= tfh_pkg::QC_W'(tfh_pkg::QUEUE_DEPTH))
   `TFH_ASSERT_IMP(a_hcount_range, 1'b1, hcount_ff <= tfh_pkg::HC_W'(tfh_pkg::HISTORY_DEPTH))
   `TFH_ASSERT_IMP(a_qwrite_room, q_wr_en, !q_full)
   `TFH_ASSERT_IMP(a_hwrite_room, h_wr_en, !h_full && (qcount_ff != '0))
   `TFH_ASSERT_NEXT(a_leave_idle, req_tvalid && req_tready && (req_tuser <= tfh_pkg::OP_LIST_H), state_ff != ST_IDLE)

endmodule

// ===== tb/testbench.sv =====
module testbench;

   // sizes and codes taken from the package
   localparam int ID_W          = tfh_pkg::ID_W;
   localparam int QUEUE_DEPTH   = tfh_pkg::QUEUE_DEPTH;
   localparam int HISTORY_DEPTH = tfh_pkg::HISTORY_DEPTH;
   localparam int QA_W          = tfh_pkg::QA_W;
   localparam int QC_W          = tfh_pkg::QC_W;
   localparam int HC_W          = tfh_pkg::HC_W;

   localparam logic [2:0] OP_OPEN   = tfh_pkg::OP_OPEN;
   localparam logic [2:0] OP_SERVE  = tfh_pkg::OP_SERVE;
   localparam logic [2:0] OP_SEARCH = tfh_pkg::OP_SEARCH;
   localparam logic [2:0] OP_LIST_Q = tfh_pkg::OP_LIST_Q;
   localparam logic [2:0] OP_LIST_H = tfh_pkg::OP_LIST_H;

   localparam logic [2:0] STS_OK        = tfh_pkg::STS_OK;
   localparam logic [2:0] STS_FULL      = tfh_pkg::STS_FULL;
   localparam logic [2:0] STS_DUP       = tfh_pkg::STS_DUP;
   localparam logic [2:0] STS_EMPTY     = tfh_pkg::STS_EMPTY;
   localparam logic [2:0] STS_NOT_FOUND = tfh_pkg::STS_NOT_FOUND;

   localparam logic [1:0] LOC_NONE    = tfh_pkg::LOC_NONE;
   localparam logic [1:0] LOC_QUEUE   = tfh_pkg::LOC_QUEUE;
   localparam logic [1:0] LOC_HISTORY = tfh_pkg::LOC_HISTORY;

   // spare op codes: the block takes the word and answers nothing
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int RANDOM_ITEMS = 420;
   localparam int QUIET_ITEMS  = 60;
   localparam int LONG_STALL   = 400;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 5000000;
   localparam int MAX_PRINTS   = 40;
   localparam int DIR_N        = 24;

   // one response word: status, id, location, drop flag, last flag
   typedef struct packed {
      logic [2:0]      status;
      logic [ID_W-1:0] rid;
      logic [1:0]      loc;
      logic            dropped;
      logic            last;
   } answer_type;

   // one directed row; typed rows carry their single answer word
   typedef struct packed {
      logic [2:0]      op;
      logic [ID_W-1:0] id;
      logic            typed;
      logic [2:0]      status;
      logic [ID_W-1:0] rid;
      logic [1:0]      loc;
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] ticket_id
   logic [2:0]  req_tuser = '0;   // [2:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] result_id
   logic [5:0]  rsp_tuser;        // [2:0] status, [4:3] location, [5] history_dropped
   logic        rsp_tlast;

   ticket_fifo_with_history_stack u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // shadow copy of the ticket stores
   logic [ID_W-1:0] q_ids [QUEUE_DEPTH];
   logic [ID_W-1:0] h_ids [HISTORY_DEPTH];
   logic [QA_W-1:0] q_head = '0;
   logic [QC_W-1:0] q_count = '0;
   logic [HC_W-1:0] h_count = '0;

   answer_type due_answers [$];

   int  cycles = 0;
   int  mismatches = 0;
   int  words_checked = 0;
   int  items_sent = 0;
   int  counted = 0;
   bit  idle_on = 1'b1;
   int  long_stalls_asked = 0;
   int  long_stalls_done = 0;
   int  rsp_hold = 0;
   int  n_full = 0, n_dup = 0, n_empty = 0, n_miss = 0, n_drop = 0, n_wrap = 0;

   step_type dir_steps [DIR_N] = '{
      '{OP_SERVE,   32'h0000_0000, 1'b1, STS_EMPTY,     32'h0000_0000, LOC_NONE},
      '{OP_LIST_Q,  32'h0000_0000, 1'b1, STS_EMPTY,     32'h0000_0000, LOC_NONE},
      '{OP_LIST_H,  32'h0000_0000, 1'b1, STS_EMPTY,     32'h0000_0000, LOC_NONE},
      '{OP_SEARCH,  32'h0000_0000, 1'b1, STS_NOT_FOUND, 32'h0000_0000, LOC_NONE},
      '{OP_OPEN,    32'h8000_0000, 1'b1, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_OPEN,    32'h7FFF_FFFF, 1'b1, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_OPEN,    32'h0000_0000, 1'b1, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_OPEN,    32'hFFFF_FFFF, 1'b1, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_OPEN,    32'h8000_0000, 1'b1, STS_DUP,       32'h0000_0000, LOC_NONE},
      '{OP_SEARCH,  32'h7FFF_FFFF, 1'b1, STS_OK,        32'h7FFF_FFFF, LOC_QUEUE},
      '{OP_SEARCH,  32'h0000_0001, 1'b1, STS_NOT_FOUND, 32'h0000_0000, LOC_NONE},
      '{OP_LIST_Q,  32'h0000_0000, 1'b0, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_SERVE,   32'h0000_0000, 1'b1, STS_OK,        32'h8000_0000, LOC_NONE},
      '{OP_SEARCH,  32'h8000_0000, 1'b1, STS_OK,        32'h8000_0000, LOC_HISTORY},
      '{OP_OPEN,    32'h8000_0000, 1'b1, STS_DUP,       32'h0000_0000, LOC_NONE},
      '{OP_LIST_H,  32'h0000_0000, 1'b0, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_SPARE_5, 32'hA5A5_A5A5, 1'b0, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_SPARE_6, 32'h5A5A_5A5A, 1'b0, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_SPARE_7, 32'hFFFF_FFFF, 1'b0, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_SERVE,   32'h0000_0000, 1'b0, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_SERVE,   32'h0000_0000, 1'b0, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_LIST_Q,  32'h0000_0000, 1'b0, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_LIST_H,  32'h0000_0000, 1'b0, STS_OK,        32'h0000_0000, LOC_NONE},
      '{OP_SEARCH,  32'hFFFF_FFFF, 1'b0, STS_OK,        32'h0000_0000, LOC_NONE}
   };

   always #1 clock = ~clock;

   function automatic answer_type make_answer(input logic [2:0] st,
                                              input logic [ID_W-1:0] id,
                                              input logic [1:0] lc, input logic dr,
                                              input logic ls);
      answer_type a;
      a.status  = st;
      a.rid     = id;
      a.loc     = lc;
      a.dropped = dr;
      a.last    = ls;
      return a;
   endfunction

   function automatic int queue_pos(input int off);
      return (int'(q_head) + off) % QUEUE_DEPTH;
   endfunction

   function automatic bit id_waiting(input logic [ID_W-1:0] id);
      for (int i = 0; i < int'(q_count); i++) begin
         if (q_ids[queue_pos(i)] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit id_served(input logic [ID_W-1:0] id);
      for (int i = int'(h_count) - 1; i >= 0; i--) begin
         if (h_ids[i] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   // work out the answer words of one request and advance the shadow stores
   function automatic void compute_ticket_answer(input logic [2:0] op,
                                                 input logic [ID_W-1:0] id,
                                                 ref answer_type out [$]);
      logic [ID_W-1:0] served;
      logic            drop;
      out.delete();
      case (op)
         OP_OPEN: begin
            if (q_count >= QC_W'(QUEUE_DEPTH)) begin
               out.push_back(make_answer(STS_FULL, '0, LOC_NONE, 1'b0, 1'b1));
               n_full++;
            end else if (id_waiting(id) || id_served(id)) begin
               out.push_back(make_answer(STS_DUP, '0, LOC_NONE, 1'b0, 1'b1));
               n_dup++;
            end else begin
               q_ids[queue_pos(int'(q_count))] = id;
               q_count++;
               out.push_back(make_answer(STS_OK, '0, LOC_NONE, 1'b0, 1'b1));
            end
         end
         OP_SERVE: begin
            if (q_count == 0) begin
               out.push_back(make_answer(STS_EMPTY, '0, LOC_NONE, 1'b0, 1'b1));
               n_empty++;
            end else begin
               served = q_ids[q_head];
               if (int'(q_head) == QUEUE_DEPTH - 1) n_wrap++;
               q_head = QA_W'(queue_pos(1));
               q_count--;
               drop = 1'b0;
               // push onto the history, or drop when it is full
               if (h_count < HC_W'(HISTORY_DEPTH)) begin
                  h_ids[h_count] = served;
                  h_count++;
               end else begin
                  drop = 1'b1;
                  n_drop++;
               end
               out.push_back(make_answer(STS_OK, served, LOC_NONE, drop, 1'b1));
            end
         end
         OP_SEARCH: begin
            if (id_waiting(id)) begin
               out.push_back(make_answer(STS_OK, id, LOC_QUEUE, 1'b0, 1'b1));
            end else if (id_served(id)) begin
               out.push_back(make_answer(STS_OK, id, LOC_HISTORY, 1'b0, 1'b1));
            end else begin
               out.push_back(make_answer(STS_NOT_FOUND, '0, LOC_NONE, 1'b0, 1'b1));
               n_miss++;
            end
         end
         OP_LIST_Q: begin
            if (q_count == 0) begin
               out.push_back(make_answer(STS_EMPTY, '0, LOC_NONE, 1'b0, 1'b1));
               n_empty++;
            end else begin
               // oldest first
               for (int i = 0; i < int'(q_count); i++) begin
                  out.push_back(make_answer(STS_OK, q_ids[queue_pos(i)], LOC_NONE, 1'b0,
                                            i == int'(q_count) - 1));
               end
            end
         end
         OP_LIST_H: begin
            if (h_count == 0) begin
               out.push_back(make_answer(STS_EMPTY, '0, LOC_NONE, 1'b0, 1'b1));
               n_empty++;
            end else begin
               // newest first
               for (int i = int'(h_count) - 1; i >= 0; i--) begin
                  out.push_back(make_answer(STS_OK, h_ids[i], LOC_NONE, 1'b0, i == 0));
               end
            end
         end
         default: ;
      endcase
   endfunction

   // pick an ID: known tickets, field extremes or anything at all
   function automatic logic [ID_W-1:0] pick_id();
      int k;
      int j;
      k = $urandom_range(0, 99);
      if (k < 25 && (q_count != 0 || h_count != 0)) begin
         j = $urandom_range(0, int'(q_count) + int'(h_count) - 1);
         if (j < int'(q_count)) return q_ids[queue_pos(j)];
         return h_ids[j - int'(q_count)];
      end
      if (k < 35) begin
         case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
         endcase
      end
      return $urandom();
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycles, msg);
   endtask

   // offer one request word and queue its answers once it is taken
   task automatic send_item(input logic [2:0] op, input logic [ID_W-1:0] id,
                            input logic typed, input answer_type typed_ans);
      answer_type fresh [$];
      if (idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 13)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= id;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      compute_ticket_answer(op, id, fresh);
      if (typed) begin
         fresh.delete();
         fresh.push_back(typed_ans);
      end
      foreach (fresh[i]) due_answers.push_back(fresh[i]);
      items_sent++;
   endtask

   task automatic random_item(input int w_open, input int w_serve, input int w_search,
                              input int w_list);
      int k;
      logic [2:0] op;
      k = $urandom_range(0, 99);
      if (k < w_open) op = OP_OPEN;
      else if (k < w_open + w_serve) op = OP_SERVE;
      else if (k < w_open + w_serve + w_search) op = OP_SEARCH;
      else if (k < w_open + w_serve + w_search + w_list)
         op = $urandom_range(0, 1) ? OP_LIST_Q : OP_LIST_H;
      else op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      send_item(op, pick_id(), 1'b0, '0);
      if (op <= OP_LIST_H) counted++;
   endtask

   // hold the sender until every queued answer has arrived
   task automatic wait_all_answered();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_answers.size() != 0) @(posedge clock);
   endtask

   // response side: long stall on request, random stall bursts otherwise
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (long_stalls_done < long_stalls_asked) begin
         long_stalls_done++;
         rsp_hold = LONG_STALL - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each response word with the oldest pending answer
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         words_checked++;
         if (due_answers.size() == 0) begin
            flag_mismatch($sformatf("unexpected word id=%h user=%h", rsp_tdata, rsp_tuser));
         end else begin
            want = due_answers.pop_front();
            if (rsp_tuser[2:0] !== want.status)
               flag_mismatch($sformatf("status %0d, want %0d", rsp_tuser[2:0], want.status));
            if (rsp_tdata !== want.rid)
               flag_mismatch($sformatf("result_id %h, want %h", rsp_tdata, want.rid));
            if (rsp_tuser[4:3] !== want.loc)
               flag_mismatch($sformatf("location %0d, want %0d", rsp_tuser[4:3], want.loc));
            if (rsp_tuser[5] !== want.dropped)
               flag_mismatch($sformatf("history_dropped %b, want %b", rsp_tuser[5],
                                       want.dropped));
            if (rsp_tlast !== want.last)
               flag_mismatch($sformatf("tlast %b, want %b", rsp_tlast, want.last));
         end
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int extra;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed rows
      for (int i = 0; i < DIR_N; i++) begin
         send_item(dir_steps[i].op, dir_steps[i].id, dir_steps[i].typed,
                   make_answer(dir_steps[i].status, dir_steps[i].rid, dir_steps[i].loc,
                               1'b0, 1'b1));
      end

      // fill the queue past full while the response side holds off
      long_stalls_asked++;
      extra = 0;
      while ((q_count < QC_W'(QUEUE_DEPTH) || extra < 25) && counted < 200) begin
         random_item(85, 3, 6, 4);
         if (q_count == QC_W'(QUEUE_DEPTH)) extra++;
      end

      // drain the queue into the history until it overflows
      extra = 0;
      while ((h_count < HC_W'(HISTORY_DEPTH) || extra < 30) && counted < 330) begin
         random_item(12, 68, 10, 6);
         if (h_count == HC_W'(HISTORY_DEPTH)) extra++;
      end
      wait_all_answered();

      // mixed traffic, then a stretch with no idling
      while (counted < RANDOM_ITEMS - QUIET_ITEMS) random_item(40, 25, 15, 12);
      idle_on = 1'b0;
      while (counted < RANDOM_ITEMS) random_item(40, 25, 15, 12);

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d requests (%0d directed), checked %0d response words",
               items_sent, DIR_N, words_checked);
      $display("saw %0d full, %0d duplicate, %0d empty, %0d not found, %0d dropped, %0d wraps",
               n_full, n_dup, n_empty, n_miss, n_drop, n_wrap);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
